@@ hw/rtl/fsr_pkg.sv @@
// shared constants, command codes and queue entry type of the shape rasterizer
package fsr_pkg;

	localparam int FB_WIDTH  = 240;
	localparam int FB_HEIGHT = 135;
	localparam int DEPTH     = FB_WIDTH * FB_HEIGHT;
	localparam int CW        = $clog2(FB_WIDTH + 1);
	localparam int RW        = $clog2(FB_HEIGHT + 1);
	localparam int AW        = $clog2(DEPTH);
	localparam int QDEPTH    = 4;
	localparam int QPW       = $clog2(QDEPTH);

	localparam logic [6:0]  BRIGHT_MAX  = 7'd100;
	// floor(p / 100) as (p * 5243) >> 19, exact for p below 43690
	localparam logic [12:0] DIV100_MUL  = 13'd5243;
	localparam int          DIV100_SH   = 19;

	typedef enum logic [3:0] {
		CMD_CLEAR     = 4'd0,
		CMD_SET_PIXEL = 4'd1,
		CMD_FILL_RECT = 4'd2,
		CMD_OUTL_RECT = 4'd3,
		CMD_FILL_ROUND = 4'd4,
		CMD_OUTL_ROUND = 4'd5,
		CMD_BMP_START = 4'd6,
		CMD_BMP_PIXEL = 4'd7,
		CMD_READ      = 4'd8
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_DRAW,
		OP_READ
	} op_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_DRAW,
		B_DRAIN,
		B_RD0,
		B_RD1,
		B_RD2,
		B_DONE
	} back_state_t;

	typedef struct packed {
		op_t                op;
		logic               outline;
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic [10:0]        w;
		logic [10:0]        h;
		logic [8:0]         r;
		logic [17:0]        r2;
		logic [17:0]        inner;
		logic [CW-1:0]      x0;
		logic [CW-1:0]      x1;
		logic [RW-1:0]      y0;
		logic [RW-1:0]      y1;
		logic [AW-1:0]      addr;
		logic [23:0]        color;
		logic               rd_in;
	} entry_t;

endpackage

@@ hw/rtl/fsr_cmd_if.sv @@
// command channel: valid, ready and one drawing request
interface fsr_cmd_if;
	logic               valid;
	logic               ready;
	logic [3:0]         cmd;
	logic signed [10:0] x;
	logic signed [10:0] y;
	logic [9:0]         w;
	logic [9:0]         h;
	logic [8:0]         radius;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic [15:0]        pixel565;

	modport source (output valid, cmd, x, y, w, h, radius, red, green, blue, pixel565,
		input ready);
	modport sink (input valid, cmd, x, y, w, h, radius, red, green, blue, pixel565,
		output ready);
endinterface

@@ hw/rtl/fsr_res_if.sv @@
// result channel: valid, ready and one readback result
interface fsr_res_if;
	logic       valid;
	logic       ready;
	logic       read_valid;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, read_valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, read_valid, out_red, out_green, out_blue, output ready);
endinterface

@@ hw/rtl/fsr_ram.sv @@
// generic simple dual port ram with registered read
module fsr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/fsr_fifo.sv @@
// short request queue between the front and the back
module fsr_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fsr_pkg::entry_t din,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output fsr_pkg::entry_t dout
);
	import fsr_pkg::*;

	entry_t         slot_q [QDEPTH];
	logic [QPW-1:0] wptr_q;
	logic [QPW-1:0] rptr_q;
	logic [QPW:0]   count_q;

	assign full  = (count_q == (QPW+1)'(QDEPTH));
	assign valid = (count_q != '0);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end
endmodule

@@ hw/rtl/fsr_front.sv @@
// front end: accepts requests, tracks the bitmap cursor, clips and clamps shapes
module fsr_front (
	input  logic            clk,
	input  logic            arst_n,
	fsr_cmd_if.sink         cmd_ch,
	input  logic            init_done,
	output logic            push,
	output fsr_pkg::entry_t push_data,
	input  logic            q_full
);
	import fsr_pkg::*;

	localparam logic signed [12:0] FBW_S = 13'(FB_WIDTH);
	localparam logic signed [12:0] FBH_S = 13'(FB_HEIGHT);

	entry_t             ent_s1;
	entry_t             s1_d;
	logic               v_s1;
	logic               accept;
	logic signed [10:0] bm_ox_q;
	logic signed [10:0] bm_oy_q;
	logic [9:0]         bm_w_q;
	logic [9:0]         bm_h_q;
	logic [9:0]         bm_col_q;
	logic [9:0]         bm_row_q;
	logic               bm_act;
	logic signed [12:0] bx, by, xe, ye, x0c, x1c, y0c, y1c;
	logic [10:0]        bw, bh, rc;
	logic               outl, box, isrd, nonempty, rd_in;
	logic [23:0]        color;
	logic [8:0]         rm1;

	assign accept        = cmd_ch.valid && cmd_ch.ready;
	assign push          = v_s1 && !q_full;
	assign cmd_ch.ready  = init_done && (!v_s1 || !q_full);
	assign bm_act        = (bm_w_q != '0) && (bm_row_q < bm_h_q);

	always_comb begin
		bx    = 13'(cmd_ch.x);
		by    = 13'(cmd_ch.y);
		bw    = {1'b0, cmd_ch.w};
		bh    = {1'b0, cmd_ch.h};
		rc    = '0;
		outl  = 1'b0;
		box   = 1'b0;
		isrd  = 1'b0;
		color = {cmd_ch.red, cmd_ch.green, cmd_ch.blue};
		unique case (cmd_t'(cmd_ch.cmd))
			CMD_CLEAR: begin
				box = 1'b1;
				bx  = '0;
				by  = '0;
				bw  = 11'(FB_WIDTH);
				bh  = 11'(FB_HEIGHT);
			end
			CMD_SET_PIXEL: begin
				box = 1'b1;
				bw  = 11'd1;
				bh  = 11'd1;
			end
			CMD_FILL_RECT: box = 1'b1;
			CMD_OUTL_RECT: begin
				box  = 1'b1;
				outl = 1'b1;
			end
			CMD_FILL_ROUND, CMD_OUTL_ROUND: begin
				box  = 1'b1;
				outl = (cmd_t'(cmd_ch.cmd) == CMD_OUTL_ROUND);
				rc   = {2'b0, cmd_ch.radius};
				if ({rc, 1'b0} > {1'b0, bw}) begin
					rc = bw >> 1;
				end
				if ({rc, 1'b0} > {1'b0, bh}) begin
					rc = bh >> 1;
				end
			end
			CMD_BMP_PIXEL: begin
				box   = bm_act && (cmd_ch.pixel565 != '0);
				bx    = 13'(bm_ox_q) + 13'(bm_col_q);
				by    = 13'(bm_oy_q) + 13'(bm_row_q);
				bw    = 11'd1;
				bh    = 11'd1;
				color = {cmd_ch.pixel565[15:11], 3'b0, cmd_ch.pixel565[10:5], 2'b0,
					cmd_ch.pixel565[4:0], 3'b0};
			end
			CMD_READ: isrd = 1'b1;
			default: ;
		endcase

		xe       = bx + 13'(bw);
		ye       = by + 13'(bh);
		x0c      = (bx < 0) ? 13'sd0 : bx;
		y0c      = (by < 0) ? 13'sd0 : by;
		x1c      = (xe > FBW_S) ? FBW_S : xe;
		y1c      = (ye > FBH_S) ? FBH_S : ye;
		nonempty = (x1c > x0c) && (y1c > y0c);
		rd_in    = (bx >= 0) && (bx < FBW_S) && (by >= 0) && (by < FBH_S);

		s1_d         = '0;
		s1_d.op      = isrd ? OP_READ : ((box && nonempty) ? OP_DRAW : OP_NOP);
		s1_d.outline = outl;
		s1_d.x       = bx[11:0];
		s1_d.y       = by[11:0];
		s1_d.w       = bw;
		s1_d.h       = bh;
		s1_d.r       = rc[8:0];
		s1_d.x0      = isrd ? CW'(bx) : CW'(x0c);
		s1_d.y0      = isrd ? RW'(by) : RW'(y0c);
		s1_d.x1      = CW'(x1c);
		s1_d.y1      = RW'(y1c);
		s1_d.color   = color;
		s1_d.rd_in   = rd_in;
	end

	// squares of r and r-1 and the row address (pixel address for a read) are formed on the way into the queue
	always_comb begin
		rm1             = ent_s1.r - 9'd1;
		push_data       = ent_s1;
		push_data.r2    = 18'({9'd0, ent_s1.r} * {9'd0, ent_s1.r});
		push_data.inner = 18'({9'd0, rm1} * {9'd0, rm1});
		push_data.addr  = AW'(ent_s1.y0 * FB_WIDTH)
			+ ((ent_s1.op == OP_READ) ? AW'(ent_s1.x0) : AW'(0));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_s1 <= s1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			bm_ox_q  <= '0;
			bm_oy_q  <= '0;
			bm_w_q   <= '0;
			bm_h_q   <= '0;
			bm_col_q <= '0;
			bm_row_q <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (push) begin
				v_s1 <= 1'b0;
			end
			if (accept && cmd_t'(cmd_ch.cmd) == CMD_BMP_START) begin
				bm_ox_q  <= cmd_ch.x;
				bm_oy_q  <= cmd_ch.y;
				bm_w_q   <= cmd_ch.w;
				bm_h_q   <= cmd_ch.h;
				bm_col_q <= '0;
				bm_row_q <= '0;
			end else if (accept && cmd_t'(cmd_ch.cmd) == CMD_BMP_PIXEL && bm_act) begin
				if ({1'b0, bm_col_q} + 11'd1 >= {1'b0, bm_w_q}) begin
					bm_col_q <= '0;
					bm_row_q <= bm_row_q + 10'd1;
				end else begin
					bm_col_q <= bm_col_q + 10'd1;
				end
			end
		end
	end
endmodule

@@ hw/rtl/fsr_back.sv @@
// back end: clears the frame store after reset, scans shapes into it, serves reads, holds the result
module fsr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  fsr_pkg::entry_t head,
	input  logic            head_valid,
	output logic            pop,
	output logic            init_done,
	input  logic [6:0]      brightness,
	fsr_res_if.source       res_ch
);
	import fsr_pkg::*;

	back_state_t   state_q, state_d;
	logic [AW-1:0] init_q;
	logic [CW-1:0] i_q;
	logic [RW-1:0] j_q;
	logic [AW-1:0] rowbase_q;
	logic          last_px;
	logic          load_out;

	logic          v_s1, v_s2, v_s3;
	logic [CW-1:0] i_s1;
	logic [RW-1:0] j_s1;
	logic [AW-1:0] addr_s1, addr_s2, addr_s3;
	logic [8:0]    dx_s2, dy_s2;
	logic          corner_s2, edge_s2, corner_s3, edge_s3;
	logic [17:0]   dx2_s3, dy2_s3;

	logic [10:0]   u, v, wmr, hmr, rr;
	logic          cu, eu, cv, ev, ue, ve;
	logic [8:0]    dx, dy;
	logic [18:0]   d2;
	logic          hit;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [23:0]   ram_wdata;
	logic [23:0]   ram_rdata;

	logic [14:0]   prod_q [3];
	logic [27:0]   quot [3];
	logic          res_rd_q;
	logic [7:0]    res_ch_q [3];
	logic          out_v_q;
	logic          out_rd_q;
	logic [7:0]    out_r_q, out_g_q, out_b_q;

	assign init_done = (state_q != B_INIT);
	assign last_px   = (i_q == head.x1 - CW'(1)) && (j_q == head.y1 - RW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_INIT: begin
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (head_valid) begin
					unique case (head.op)
						OP_DRAW: state_d = B_DRAW;
						OP_READ: state_d = B_RD0;
						default: state_d = B_DONE;
					endcase
				end
			end
			B_DRAW: begin
				if (last_px) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = B_DONE;
				end
			end
			B_RD0: state_d = head.rd_in ? B_RD1 : B_DONE;
			B_RD1: state_d = B_RD2;
			B_RD2: state_d = B_DONE;
			B_DONE: begin
				if (!out_v_q || res_ch.ready) begin
					load_out = 1'b1;
					pop      = 1'b1;
					state_d  = B_IDLE;
				end
			end
		endcase
	end

	// clearing pass address counter and valid flags of the scan pipeline; the scan counters follow
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
		end else begin
			if (state_q == B_INIT) begin
				init_q <= init_q + AW'(1);
			end
			v_s1 <= (state_q == B_DRAW);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			i_q       <= head.x0;
			j_q       <= head.y0;
			rowbase_q <= head.addr;
		end else if (state_q == B_DRAW) begin
			if (i_q == head.x1 - CW'(1)) begin
				i_q       <= head.x0;
				j_q       <= j_q + RW'(1);
				rowbase_q <= rowbase_q + AW'(FB_WIDTH);
			end else begin
				i_q <= i_q + CW'(1);
			end
		end
		i_s1    <= i_q;
		j_s1    <= j_q;
		addr_s1 <= rowbase_q + AW'(i_q);
	end

	// offsets inside the shape and corner zone of each pixel
	always_comb begin
		rr  = {2'b0, head.r};
		u   = 11'(12'(i_s1) - head.x);
		v   = 11'(12'(j_s1) - head.y);
		wmr = head.w - rr;
		hmr = head.h - rr;
		cu  = (u < rr);
		eu  = (u >= wmr);
		cv  = (v < rr);
		ev  = (v >= hmr);
		dx  = cu ? 9'(rr - 11'd1 - u) : 9'(u - wmr);
		dy  = cv ? 9'(rr - 11'd1 - v) : 9'(v - hmr);
		ue  = (u == '0) || (u == head.w - 11'd1);
		ve  = (v == '0) || (v == head.h - 11'd1);
	end

	always_ff @(posedge clk) begin
		dx_s2     <= dx;
		dy_s2     <= dy;
		corner_s2 <= (cu || eu) && (cv || ev);
		edge_s2   <= (!cu && !eu && ve) || (!cv && !ev && ue);
		addr_s2   <= addr_s1;
		dx2_s3    <= 18'({9'd0, dx_s2} * {9'd0, dx_s2});
		dy2_s3    <= 18'({9'd0, dy_s2} * {9'd0, dy_s2});
		corner_s3 <= corner_s2;
		edge_s3   <= edge_s2;
		addr_s3   <= addr_s2;
	end

	always_comb begin
		d2 = 19'(dx2_s3) + 19'(dy2_s3);
		if (corner_s3) begin
			hit = (d2 <= 19'(head.r2)) && (!head.outline || d2 >= 19'(head.inner));
		end else begin
			hit = !head.outline || edge_s3;
		end
	end

	// reset clearing pass shares the write port with the scan
	assign ram_we    = (state_q == B_INIT) || (v_s3 && hit);
	assign ram_waddr = (state_q == B_INIT) ? init_q : addr_s3;
	assign ram_wdata = (state_q == B_INIT) ? 24'd0 : head.color;

	fsr_ram #(
		.WIDTH(24),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head.addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			quot[k] = 28'(prod_q[k]) * 28'(DIV100_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_RD1) begin
			prod_q[0] <= 15'(ram_rdata[23:16]) * 15'(brightness);
			prod_q[1] <= 15'(ram_rdata[15:8]) * 15'(brightness);
			prod_q[2] <= 15'(ram_rdata[7:0]) * 15'(brightness);
		end
		if (state_q == B_IDLE) begin
			res_rd_q <= (head.op == OP_READ);
			for (int k = 0; k < 3; k++) begin
				res_ch_q[k] <= '0;
			end
		end else if (state_q == B_RD2) begin
			for (int k = 0; k < 3; k++) begin
				res_ch_q[k] <= quot[k][DIV100_SH +: 8];
			end
		end
		if (load_out) begin
			out_rd_q <= res_rd_q;
			out_r_q  <= res_ch_q[0];
			out_g_q  <= res_ch_q[1];
			out_b_q  <= res_ch_q[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load_out) begin
			out_v_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign res_ch.valid      = out_v_q;
	assign res_ch.read_valid = out_rd_q;
	assign res_ch.out_red    = out_r_q;
	assign res_ch.out_green  = out_g_q;
	assign res_ch.out_blue   = out_b_q;

	a_no_write_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_RD0 || state_q == B_RD1 || state_q == B_RD2) |-> !ram_we)
		else $error("frame store written during a read");
	a_pop_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == B_DONE && head_valid))
		else $error("queue popped outside result hand-off");
	a_init_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		init_done |=> init_done)
		else $error("clearing pass restarted");
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DONE) |-> (!v_s1 && !v_s2 && !v_s3))
		else $error("result taken with pixels still in flight");
endmodule

@@ hw/rtl/framebuffer_shape_rasterizer_unit.sv @@
// top level: apb register, front end, request queue and back end of the rasterizer
//
// Requests arrive on cmd_ch (valid/ready); each one gives exactly one result on
// res_ch, in request order. Only read requests carry pixel data; all others
// return read_valid 0 with zero channels.
// Draw requests scan each pixel of the shape's bounding box after clipping
// to the frame, one frame store word a cycle, then drain the pixel pipeline
// and hand off the result, which waits while res_ch stalls.
// A clear sweeps the whole frame. Reads pass through the registered frame
// store read and the two dimming multiplies; a read outside the frame skips
// them. Requests that change no pixel go straight to the result hand-off.
// After reset the back end clears all FB_WIDTH*FB_HEIGHT words of the frame
// store (32400 at 240x135), one word a cycle; cmd_ch.ready stays low until
// then, while brightness writes on the apb port are taken as usual.
// When res_ch stalls, the back end holds one finished result in its output
// register and waits; the front end keeps accepting until the queue fills.
module framebuffer_shape_rasterizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	fsr_cmd_if.sink     cmd_ch,
	fsr_res_if.source   res_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import fsr_pkg::*;

	localparam logic REG_BRIGHTNESS = 1'b0;

	logic [6:0] bright_q;
	logic       push, q_full, pop, q_valid, init_done;
	entry_t     push_data, head;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BRIGHTNESS) ? {25'd0, bright_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q <= BRIGHT_MAX;
		end else if (psel && penable && pwrite && paddr[2] == REG_BRIGHTNESS) begin
			bright_q <= (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];
		end
	end

	fsr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_ch   (cmd_ch),
		.init_done(init_done),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	fsr_fifo u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (push_data),
		.full  (q_full),
		.pop   (pop),
		.valid (q_valid),
		.dout  (head)
	);

	fsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.head_valid(q_valid),
		.pop       (pop),
		.init_done (init_done),
		.brightness(bright_q),
		.res_ch    (res_ch)
	);
endmodule
